// ===== hdl/cbe_pkg.sv =====
`default_nettype none

package cbe_pkg;

    // Output / input format
    localparam int FRAC_BITS    = 16;
    localparam int IN_W         = 17;
    localparam int NEWTON_STEPS = 8;

    // Internal Q format: unsigned Q30 for values in [0, 1]
    localparam int QB       = 30;
    localparam int DIV_BITS = QB + 2;   // quotient bits kept before saturation

    typedef logic [QB:0]            t_q;    // [0, ONE]
    typedef logic signed [QB+4:0]   t_s;    // signed sums of a few Q30 terms
    typedef logic [QB+3:0]          t_m;    // magnitude of the Newton residual
    typedef logic [QB+2:0]          t_d;    // positive derivative
    typedef logic [2*QB+4:0]        t_r;    // divider numerator / remainder
    typedef logic [DIV_BITS-1:0]    t_quo;

    localparam t_q Q_ONE     = t_q'(1) << QB;
    localparam t_q CP_X1     = t_q'((2 * (64'(1) << QB) + 2) / 5);
    localparam t_q CP_X2     = t_q'(((64'(1) << QB) + 2) / 5);
    localparam t_q CP_DX     = CP_X1 - CP_X2;      // magnitude of x2 - x1
    localparam t_q CP_RX     = Q_ONE - CP_X2;
    localparam t_s DERIV_EPS = t_s'(((64'(1) << QB) + 500000) / 1000000);

    localparam t_q ONE_IN    = t_q'(64'(1) << FRAC_BITS);
    localparam t_q HALF_OUT  = t_q'((64'(1) << (QB - FRAC_BITS)) >> 1);

    localparam logic [2*QB+1:0] Q_RND = (2*QB+2)'(1) << (QB - 1);

    // Q30 product of two values in [0, 1], rounded to nearest
    function automatic t_q qmul(input t_q a, input t_q b);
        logic [2*QB+1:0] p;
        p = (2*QB+2)'(a) * (2*QB+2)'(b) + Q_RND;
        return p[2*QB:QB];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cbe_step.sv =====
`default_nettype none

// One Newton step: 5 arithmetic stages, DIV_BITS restoring-divide stages, 1 update stage.
module cbe_step
    import cbe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_q   i_t,
    input  wire t_q   i_x,
    output logic      o_vld,
    output t_q        o_t,
    output t_q        o_x
);

    localparam int STG = 6 + DIV_BITS;

    logic [STG-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STG-2:0], i_vld};
        end
    end

    assign o_vld = r_vld[STG-1];

    // stage 1: basis squares
    t_q w_mt;
    t_q r1_a, r1_b, r1_c, r1_t, r1_x;
    assign w_mt = Q_ONE - i_t;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a <= qmul(w_mt, w_mt);
            r1_b <= qmul(i_t, i_t);
            r1_c <= qmul(w_mt, i_t);
            r1_t <= i_t;
            r1_x <= i_x;
        end
    end

    // stage 2: cubic terms and derivative terms
    t_q r2_p1, r2_p2, r2_p3, r2_d1, r2_d2, r2_d3, r2_t, r2_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p1 <= qmul(r1_a, r1_t);
            r2_p2 <= qmul(r1_c, r1_t);
            r2_p3 <= qmul(r1_b, r1_t);
            r2_d1 <= qmul(r1_a, CP_X1);
            r2_d2 <= qmul(r1_c, CP_DX);
            r2_d3 <= qmul(r1_b, CP_RX);
            r2_t  <= r1_t;
            r2_x  <= r1_x;
        end
    end

    // stage 3: control-point weights, derivative sum
    t_q r3_e1, r3_e2, r3_p3, r3_t, r3_x;
    t_s r3_dbx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_e1  <= qmul(r2_p1, CP_X1);
            r3_e2  <= qmul(r2_p2, CP_X2);
            r3_p3  <= r2_p3;
            r3_dbx <= t_s'(3) * t_s'(r2_d1) - t_s'(6) * t_s'(r2_d2)
                    + t_s'(3) * t_s'(r2_d3);
            r3_t   <= r2_t;
            r3_x   <= r2_x;
        end
    end

    // stage 4: residual, sign and flat-derivative check
    t_s w_bx, w_n, w_abs;
    logic r4_neg, r4_skip;
    t_m   r4_mag;
    t_d   r4_d;
    t_q   r4_t, r4_x;

    assign w_bx  = t_s'(3) * t_s'(r3_e1) + t_s'(3) * t_s'(r3_e2) + t_s'(r3_p3);
    assign w_n   = w_bx - t_s'(r3_x);
    assign w_abs = (w_n < 0) ? -w_n : w_n;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_neg  <= w_n < 0;
            r4_mag  <= w_abs[QB+3:0];
            r4_skip <= r3_dbx < DERIV_EPS;
            r4_d    <= r3_dbx[QB+2:0];
            r4_t    <= r3_t;
            r4_x    <= r3_x;
        end
    end

    // stage 5: rounded numerator, quotient overflow check
    t_r w_num;
    assign w_num = {1'b0, r4_mag, QB'(0)} + t_r'(r4_d >> 1);

    t_r   r_rem  [0:DIV_BITS-1];
    t_d   r_dv   [0:DIV_BITS-1];
    t_quo r_quo  [0:DIV_BITS];
    t_q   r_tt   [0:DIV_BITS];
    t_q   r_xx   [0:DIV_BITS];
    logic r_neg  [0:DIV_BITS];
    logic r_skip [0:DIV_BITS];
    logic r_sat  [0:DIV_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_num;
            r_dv[0]   <= r4_d;
            r_quo[0]  <= '0;
            r_tt[0]   <= r4_t;
            r_xx[0]   <= r4_x;
            r_neg[0]  <= r4_neg;
            r_skip[0] <= r4_skip;
            r_sat[0]  <= w_num >= {r4_d, DIV_BITS'(0)};
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
        localparam int K = DIV_BITS - 1 - j;
        t_r   w_sh;
        logic w_ge;
        assign w_sh = t_r'(r_dv[j]) << K;
        assign w_ge = r_rem[j] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j+1]  <= {r_quo[j][DIV_BITS-2:0], w_ge};
                r_tt[j+1]   <= r_tt[j];
                r_xx[j+1]   <= r_xx[j];
                r_neg[j+1]  <= r_neg[j];
                r_skip[j+1] <= r_skip[j];
                r_sat[j+1]  <= r_sat[j];
            end
        end

        if (j < DIV_BITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? (r_rem[j] - w_sh) : r_rem[j];
                    r_dv[j+1]  <= r_dv[j];
                end
            end
        end
    end

    // update stage: t -/+ q, clamped to [0, ONE]; t is held when the derivative is flat
    logic [DIV_BITS:0] w_sum;
    t_quo              w_tq;
    t_q                n_t;
    t_q                r_t_out, r_x_out;

    assign w_sum = (DIV_BITS+1)'(r_tt[DIV_BITS]) + (DIV_BITS+1)'(r_quo[DIV_BITS]);
    assign w_tq  = DIV_BITS'(r_tt[DIV_BITS]);

    always_comb begin
        if (r_skip[DIV_BITS]) begin
            n_t = r_tt[DIV_BITS];
        end else if (r_sat[DIV_BITS]) begin
            n_t = r_neg[DIV_BITS] ? Q_ONE : '0;
        end else if (r_neg[DIV_BITS]) begin
            n_t = (w_sum > (DIV_BITS+1)'(Q_ONE)) ? Q_ONE : w_sum[QB:0];
        end else if (w_tq >= r_quo[DIV_BITS]) begin
            n_t = t_q'(w_tq - r_quo[DIV_BITS]);
        end else begin
            n_t = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t_out <= n_t;
            r_x_out <= r_xx[DIV_BITS];
        end
    end

    assign o_t = r_t_out;
    assign o_x = r_x_out;

endmodule

`default_nettype wire

// ===== hdl/cubic_bezier_ease_eval.sv =====
`default_nettype none

// Cubic-bezier ease curve, control points (0.4, 0) and (0.2, 1). Takes progress x in
// unsigned 1.16 fixed point (65536 = 1.0, larger values saturate to 1.0) and returns the
// eased y in the same format. Fully pipelined: one transaction in and one out per clock
// when the output side is ready. Most of the pipeline depth lies in the eight unrolled
// Newton steps, each carrying a 32-stage restoring divider. The whole pipeline advances
// on one enable; it halts only while a result sits unclaimed at the output.
module cubic_bezier_ease_eval
    import cbe_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_progress_valid,
    output logic                 o_progress_ready,
    input  wire logic [IN_W-1:0] i_progress,
    output logic                 o_eased_valid,
    input  wire logic            i_eased_ready,
    output logic [IN_W-1:0]      o_eased
);

    // pipeline enable: move unless the output register holds an unclaimed result
    logic w_en;
    assign w_en             = !o_eased_valid || i_eased_ready;
    assign o_progress_ready = w_en;

    // input stage: saturate to one and scale to Q30
    t_q   w_p;
    logic r_in_v;
    t_q   r_in_x;

    assign w_p = (t_q'(i_progress) > ONE_IN) ? ONE_IN : t_q'(i_progress);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_progress_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_x <= w_p << (QB - FRAC_BITS);
        end
    end

    // Newton chain, starting guess t = x
    logic [NEWTON_STEPS:0] w_v;
    t_q                    w_t [0:NEWTON_STEPS];
    t_q                    w_x [0:NEWTON_STEPS];

    assign w_v[0] = r_in_v;
    assign w_t[0] = r_in_x;
    assign w_x[0] = r_in_x;

    for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
        cbe_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_v[k]),
            .i_t     (w_t[k]),
            .i_x     (w_x[k]),
            .o_vld   (w_v[k+1]),
            .o_t     (w_t[k+1]),
            .o_x     (w_x[k+1])
        );
    end

    // y(t) = 3*(1-t)*t^2 + t^3
    t_q                w_ymt;
    logic [2:0]        r_yv;
    t_q                r_yb, r_yc, r_yt;
    logic [QB+2:0]     r_ys;
    t_q                w_ycl, w_yr;
    logic [IN_W-1:0]   r_out;

    assign w_ymt = Q_ONE - w_t[NEWTON_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yv <= '0;
        end else if (w_en) begin
            r_yv <= {r_yv[1:0], w_v[NEWTON_STEPS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yb <= qmul(w_t[NEWTON_STEPS], w_t[NEWTON_STEPS]);
            r_yc <= qmul(w_ymt, w_t[NEWTON_STEPS]);
            r_yt <= w_t[NEWTON_STEPS];
            r_ys <= (QB+3)'(3) * (QB+3)'(qmul(r_yc, r_yt)) + (QB+3)'(qmul(r_yb, r_yt));
            r_out <= w_yr[IN_W-1:0];
        end
    end

    // clamp to one, round to FRAC_BITS, clamp again (only matters for wide formats)
    logic [QB+1:0] w_rnd;
    assign w_ycl = (r_ys > (QB+3)'(Q_ONE)) ? Q_ONE : r_ys[QB:0];
    assign w_rnd = ((QB+2)'(w_ycl) + (QB+2)'(HALF_OUT)) >> (QB - FRAC_BITS);
    assign w_yr  = (w_rnd > (QB+2)'(ONE_IN)) ? ONE_IN : w_rnd[QB:0];

    assign o_eased_valid = r_yv[2];
    assign o_eased       = r_out;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_eased_valid && !i_eased_ready) |-> !o_progress_ready)
        else $error("input accepted while output stalled");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_eased_valid |-> (t_q'(o_eased) <= ONE_IN))
        else $error("eased value above one");

    a_newton_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_v[NEWTON_STEPS] |-> (w_t[NEWTON_STEPS] <= Q_ONE && w_x[NEWTON_STEPS] <= Q_ONE))
        else $error("Newton parameter out of unit range");
`endif

endmodule

`default_nettype wire
